>>> sv/rrfe_pkg.sv
package rrfe_pkg;

    localparam int RING_BASE_BITS       = 13;
    localparam int DEF_RING_OFFSET_BITS = 16;
    localparam int MIN_RING_OFFSET_BITS = 13;
    localparam int MAX_RING_OFFSET_BITS = 16;

    localparam logic [1:0]  RING_CODE_RESET = 2'd3;
    localparam logic [15:0] LEN_NOT_READY   = 16'hFFF0;
    localparam int          STATUS_OK_BIT   = 0;
    localparam logic [15:0] RP_BIAS         = 16'd16;
    localparam logic [15:0] CRC_BYTES       = 16'd4;
    localparam logic [15:0] RP_AFTER_RESET  = 16'hFFF0;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_PAD    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        HDR_STATUS_LO = 2'd0,
        HDR_STATUS_HI = 2'd1,
        HDR_LENGTH_LO = 2'd2,
        HDR_LENGTH_HI = 2'd3
    } t_hdr_idx;

    typedef enum logic [1:0] {
        KIND_PACKET     = 2'd0,
        KIND_EMPTY      = 2'd1,
        KIND_NOT_READY  = 2'd2,
        KIND_BAD_STATUS = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  packet_byte;
        logic        last_flag;
        logic [15:0] frame_length;
        logic [15:0] frame_status;
        logic [15:0] read_pointer;
    } t_result;

endpackage

>>> sv/rrfe_core.sv
module rrfe_core #(
    parameter int RING_OFFSET_BITS = rrfe_pkg::DEF_RING_OFFSET_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_ring_byte,
    input  logic [1:0]        i_ring_size_code,
    output logic              o_res_valid,
    output rrfe_pkg::t_result o_res
);
    import rrfe_pkg::*;

    localparam int W = RING_OFFSET_BITS;

    t_phase      r_phase,    n_phase;
    t_hdr_idx    r_hdr_idx,  n_hdr_idx;
    logic [15:0] r_status,   n_status;
    logic [15:0] r_length,   n_length;
    logic [15:0] r_body_rem, n_body_rem;
    logic [W-1:0] r_offset,  n_offset;
    logic [1:0]  r_pad,      n_pad;
    logic [15:0] r_end_ptr,  n_end_ptr;
    logic [W-1:0] r_end_off, n_end_off;

    logic [W-1:0] ring_mask;
    logic [15:0]  hdr_len;
    logic [W-1:0] start;
    logic [W-1:0] start4;
    logic [W-1:0] end_raw;
    logic [W:0]   aligned;
    logic [16:0]  end_ptr_wide;
    logic [16:0]  start_ptr_wide;
    logic [W-1:0] end_off;
    logic [1:0]   pad_calc;
    logic [15:0]  body_dec;
    logic [15:0]  flen;

    always_comb begin
        if (RING_BASE_BITS + int'(i_ring_size_code) >= W) begin
            ring_mask = {W{1'b1}};
        end else begin
            ring_mask = {W{1'b1}} >> (W - RING_BASE_BITS - int'(i_ring_size_code));
        end
    end

    assign hdr_len        = {i_ring_byte, r_length[7:0]};
    assign start          = r_offset & ring_mask;
    assign start4         = W'(start + W'(4)) & ring_mask;
    assign end_raw        = W'(start4 + hdr_len[W-1:0]) & ring_mask;
    assign aligned        = ({1'b0, end_raw} + (W+1)'(3)) & ~(W+1)'(3);
    assign end_ptr_wide   = 17'(aligned) - 17'(RP_BIAS);
    assign start_ptr_wide = 17'(start) - 17'(RP_BIAS);
    assign end_off        = aligned[W-1:0] & ring_mask;
    assign pad_calc       = 2'(~end_raw[1:0] + 2'd1);
    assign body_dec       = r_body_rem - 16'd1;
    assign flen           = (r_length >= CRC_BYTES) ? (r_length - CRC_BYTES) : 16'd0;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_status   = r_status;
        n_length   = r_length;
        n_body_rem = r_body_rem;
        n_offset   = r_offset;
        n_pad      = r_pad;
        n_end_ptr  = r_end_ptr;
        n_end_off  = r_end_off;

        o_res_valid        = 1'b0;
        o_res.kind         = KIND_PACKET;
        o_res.packet_byte  = 8'd0;
        o_res.last_flag    = 1'b0;
        o_res.frame_length = 16'd0;
        o_res.frame_status = r_status;
        o_res.read_pointer = 16'd0;

        if (i_fire) begin
            unique case (r_phase)
                PH_BODY: begin
                    n_body_rem        = body_dec;
                    o_res_valid       = 1'b1;
                    o_res.packet_byte = i_ring_byte;
                    if (body_dec != 16'd0) begin
                        n_offset = W'(r_offset + W'(1)) & ring_mask;
                    end else begin
                        n_offset           = r_end_off;
                        n_phase            = (r_pad != 2'd0) ? PH_PAD : PH_HEADER;
                        o_res.last_flag    = 1'b1;
                        o_res.frame_length = flen;
                        o_res.read_pointer = r_end_ptr;
                    end
                end
                PH_PAD: begin
                    n_pad = r_pad - 2'd1;
                    if (n_pad == 2'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    unique case (r_hdr_idx)
                        HDR_STATUS_LO: begin
                            n_status  = {8'd0, i_ring_byte};
                            n_hdr_idx = HDR_STATUS_HI;
                        end
                        HDR_STATUS_HI: begin
                            n_status  = {i_ring_byte, r_status[7:0]};
                            n_hdr_idx = HDR_LENGTH_LO;
                        end
                        HDR_LENGTH_LO: begin
                            n_length  = {8'd0, i_ring_byte};
                            n_hdr_idx = HDR_LENGTH_HI;
                        end
                        HDR_LENGTH_HI: begin
                            n_length    = hdr_len;
                            n_hdr_idx   = HDR_STATUS_LO;
                            o_res_valid = 1'b1;
                            priority if (hdr_len == LEN_NOT_READY) begin
                                n_offset           = start;
                                o_res.kind         = KIND_NOT_READY;
                                o_res.read_pointer = start_ptr_wide[15:0];
                            end else if (!r_status[STATUS_OK_BIT]) begin
                                n_offset           = '0;
                                o_res.kind         = KIND_BAD_STATUS;
                                o_res.read_pointer = RP_AFTER_RESET;
                            end else begin
                                n_end_ptr = end_ptr_wide[15:0];
                                n_end_off = end_off;
                                if (hdr_len == 16'd0) begin
                                    n_offset           = end_off;
                                    n_pad              = 2'd0;
                                    o_res.kind         = KIND_EMPTY;
                                    o_res.read_pointer = end_ptr_wide[15:0];
                                end else begin
                                    o_res_valid = 1'b0;
                                    n_offset    = start4;
                                    n_pad       = pad_calc;
                                    n_body_rem  = hdr_len;
                                    n_phase     = PH_BODY;
                                end
                            end
                        end
                        default: begin
                            n_hdr_idx = HDR_STATUS_LO;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= HDR_STATUS_LO;
            r_status   <= '0;
            r_length   <= '0;
            r_body_rem <= '0;
            r_offset   <= '0;
            r_pad      <= '0;
            r_end_ptr  <= '0;
            r_end_off  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_status   <= n_status;
            r_length   <= n_length;
            r_body_rem <= n_body_rem;
            r_offset   <= n_offset;
            r_pad      <= n_pad;
            r_end_ptr  <= n_end_ptr;
            r_end_off  <= n_end_off;
        end
    end

endmodule

>>> sv/rrfe_skid.sv
module rrfe_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rrfe_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output rrfe_pkg::t_result o_data
);
    import rrfe_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        priority if (take && r_skid_valid) begin
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end else if (take || !r_out_valid) begin
            n_out_valid = i_push;
            n_out       = i_data;
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> sv/receive_ring_frame_extractor.sv
// A result waits in the output register or skid; input stalls while the skid is full.
// Otherwise one ring byte is taken per cycle; header and padding bytes give no result.
// A two-entry output register and skid stage keep input flowing while one result waits.
// Reset (synchronous, active low): parser back to header phase, offset 0,
// ring size code 3 (64K), no results pending.
module receive_ring_frame_extractor #(
    parameter int RING_OFFSET_BITS = rrfe_pkg::DEF_RING_OFFSET_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ring_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_ring_size_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_packet_byte,
    output logic        o_last_flag,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_frame_status,
    output logic [15:0] o_read_pointer
);
    import rrfe_pkg::*;

    logic [1:0] r_ring_size_code;
    logic       fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;
    logic       skid_full;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !skid_full;
    assign fire        = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size_code <= RING_CODE_RESET;
        end else if (i_cfg_valid) begin
            r_ring_size_code <= i_cfg_ring_size_code;
        end
    end

    rrfe_core #(
        .RING_OFFSET_BITS(RING_OFFSET_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_ring_byte     (i_ring_byte),
        .i_ring_size_code(r_ring_size_code),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    rrfe_skid u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid),
        .i_data (res),
        .o_full (skid_full),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (out_res)
    );

    assign o_result_kind  = out_res.kind;
    assign o_packet_byte  = out_res.packet_byte;
    assign o_last_flag    = out_res.last_flag;
    assign o_frame_length = out_res.frame_length;
    assign o_frame_status = out_res.frame_status;
    assign o_read_pointer = out_res.read_pointer;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("skid holds a request while output register is empty");

    a_last_is_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_flag) |-> (o_result_kind == KIND_PACKET))
        else $error("last flag on a non-packet result");

    a_bad_status_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_BAD_STATUS)) |-> (o_read_pointer == RP_AFTER_RESET))
        else $error("receiver reset result with wrong read pointer");

    a_no_byte_off_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind != KIND_PACKET)) |->
        (o_packet_byte == 8'd0 && o_frame_length == 16'd0))
        else $error("non-packet result carries byte or length");
`endif

endmodule

>>> test/receive_ring_frame_extractor_tb.sv
`timescale 1ns / 1ps

module receive_ring_frame_extractor_tb;
    import rrfe_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          PHASE_BYTES    = 270;
    localparam logic [15:0] HEADER_BYTES   = 16'd4;

    class frame_checker;
        logic [1:0]  ring_size_code;
        t_phase      parse_phase;
        t_hdr_idx    header_index;
        logic [15:0] status_word;
        logic [15:0] length_word;
        logic [15:0] body_remaining;
        logic [15:0] ring_offset;
        logic [1:0]  pad_remaining;
        logic [15:0] end_pointer;
        logic [15:0] end_offset;
        t_result     pending_results [$];
        int          errors;
        int          kind_seen [4];

        function new();
            ring_size_code = RING_CODE_RESET;
            parse_phase    = PH_HEADER;
            header_index   = HDR_STATUS_LO;
            status_word    = '0;
            length_word    = '0;
            body_remaining = '0;
            ring_offset    = '0;
            pad_remaining  = '0;
            end_pointer    = '0;
            end_offset     = '0;
            errors         = 0;
            kind_seen      = '{0, 0, 0, 0};
        endfunction

        function void set_ring_code(logic [1:0] code);
            ring_size_code = code;
        endfunction

        function int unsigned ring_len();
            int unsigned bits;
            bits = RING_BASE_BITS + ring_size_code;
            if (bits > DEF_RING_OFFSET_BITS) begin
                bits = DEF_RING_OFFSET_BITS;
            end
            return 32'd1 << bits;
        endfunction

        function logic [15:0] ring_mask();
            return 16'(ring_len() - 1);
        endfunction

        function void note_ring_byte(logic [7:0] b);
            logic [15:0] mask;
            logic [15:0] start;
            logic [15:0] fin;
            logic [16:0] aligned;
            logic        produced;
            t_result     r;
            mask     = ring_mask();
            r        = '0;
            produced = 1'b0;
            case (parse_phase)
                PH_BODY: begin
                    body_remaining = body_remaining - 16'd1;
                    produced       = 1'b1;
                    r.kind         = KIND_PACKET;
                    r.packet_byte  = b;
                    r.frame_status = status_word;
                    if (body_remaining != 16'd0) begin
                        ring_offset = (ring_offset + 16'd1) & mask;
                    end else begin
                        ring_offset    = end_offset;
                        parse_phase    = (pad_remaining != 2'd0) ? PH_PAD : PH_HEADER;
                        r.last_flag    = 1'b1;
                        r.frame_length = (length_word >= CRC_BYTES) ?
                                         length_word - CRC_BYTES : 16'd0;
                        r.read_pointer = end_pointer;
                    end
                end
                PH_PAD: begin
                    pad_remaining = pad_remaining - 2'd1;
                    if (pad_remaining == 2'd0) begin
                        parse_phase = PH_HEADER;
                    end
                end
                default: begin
                    parse_phase = PH_HEADER;
                    case (header_index)
                        HDR_STATUS_LO: status_word = {8'h00, b};
                        HDR_STATUS_HI: status_word[15:8] = b;
                        HDR_LENGTH_LO: length_word = {8'h00, b};
                        default:       length_word[15:8] = b;
                    endcase
                    if (header_index != HDR_LENGTH_HI) begin
                        header_index = t_hdr_idx'(header_index + 2'd1);
                    end else begin
                        header_index   = HDR_STATUS_LO;
                        start          = ring_offset & mask;
                        produced       = 1'b1;
                        r.frame_status = status_word;
                        if (length_word == LEN_NOT_READY) begin
                            ring_offset    = start;
                            r.kind         = KIND_NOT_READY;
                            r.read_pointer = start - RP_BIAS;
                        end else if (!status_word[STATUS_OK_BIT]) begin
                            ring_offset    = '0;
                            r.kind         = KIND_BAD_STATUS;
                            r.read_pointer = RP_AFTER_RESET;
                        end else begin
                            start         = (start + HEADER_BYTES) & mask;
                            fin           = (start + length_word) & mask;
                            aligned       = ({1'b0, fin} + 17'd3) & ~17'd3;
                            pad_remaining = 2'(aligned - {1'b0, fin});
                            end_pointer   = 16'(aligned - {1'b0, RP_BIAS});
                            end_offset    = aligned[15:0] & mask;
                            if (length_word == 16'd0) begin
                                ring_offset    = end_offset;
                                pad_remaining  = '0;
                                r.kind         = KIND_EMPTY;
                                r.read_pointer = end_pointer;
                            end else begin
                                ring_offset    = start;
                                body_remaining = length_word;
                                parse_phase    = PH_BODY;
                                produced       = 1'b0;
                            end
                        end
                    end
                end
            endcase
            if (produced) begin
                pending_results.push_back(r);
            end
        endfunction

        function void compare_field(string label, logic [15:0] want, logic [15:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, seen);
            end
        endfunction

        function void check_result(t_result seen);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            end else begin
                want = pending_results.pop_front();
                compare_field("result_kind", want.kind, seen.kind);
                compare_field("packet_byte", want.packet_byte, seen.packet_byte);
                compare_field("last_flag", want.last_flag, seen.last_flag);
                compare_field("frame_length", want.frame_length, seen.frame_length);
                compare_field("frame_status", want.frame_status, seen.frame_status);
                compare_field("read_pointer", want.read_pointer, seen.read_pointer);
                if (!$isunknown(seen.kind)) begin
                    kind_seen[seen.kind]++;
                end
            end
        endfunction
    endclass

    logic        i_clk                = 1'b0;
    logic        i_rst_n              = 1'b0;
    logic        i_valid              = 1'b0;
    logic [7:0]  i_ring_byte          = '0;
    logic        i_cfg_valid          = 1'b0;
    logic [1:0]  i_cfg_ring_size_code = '0;
    logic        i_ready              = 1'b0;
    logic        o_ready;
    logic        o_cfg_ready;
    logic        o_valid;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_packet_byte;
    logic        o_last_flag;
    logic [15:0] o_frame_length;
    logic [15:0] o_frame_status;
    logic [15:0] o_read_pointer;

    frame_checker ring;
    t_result      observed;
    int unsigned  items_sent   = 0;
    int unsigned  quiet_cycles = 0;
    bit           no_gaps      = 1'b0;
    bit           rx_hold_req  = 1'b0;

    receive_ring_frame_extractor DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_ring_byte          (i_ring_byte),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_ring_size_code (i_cfg_ring_size_code),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_result_kind        (o_result_kind),
        .o_packet_byte        (o_packet_byte),
        .o_last_flag          (o_last_flag),
        .o_frame_length       (o_frame_length),
        .o_frame_status       (o_frame_status),
        .o_read_pointer       (o_read_pointer)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_ring_byte(input logic [7:0] value);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < 23) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_ring_byte <= value;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        ring.note_ring_byte(value);
        items_sent++;
    endtask

    // header, then body and padding for as long as the parser stays out of header phase
    task automatic send_frame(input logic [15:0] status, input logic [15:0] length);
        send_ring_byte(status[7:0]);
        send_ring_byte(status[15:8]);
        send_ring_byte(length[7:0]);
        send_ring_byte(length[15:8]);
        while (ring.parse_phase != PH_HEADER) begin
            send_ring_byte(8'($urandom));
        end
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        logic [15:0] status;
        logic [15:0] length;
        pick   = $urandom_range(0, 99);
        status = 16'($urandom) | 16'h0001;
        length = 16'($urandom_range(5, 48));
        if (pick < 6) begin
            length = LEN_NOT_READY;
        end else if (pick < 14) begin
            status = status & ~16'h0001;
            length = 16'($urandom);
        end else if (pick < 20) begin
            length = 16'd0;
        end else if (pick < 30) begin
            length = 16'($urandom_range(1, 4));
        end else if (pick < 33) begin
            length = 16'($urandom_range(49, 400));
        end else if (pick < 38) begin
            status = 16'($urandom);
            length = $urandom_range(0, 1) ? LEN_NOT_READY : 16'($urandom_range(0, 63));
        end
        send_frame(status, length);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (ring.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring_size(input logic [1:0] code);
        i_cfg_valid          <= 1'b1;
        i_cfg_ring_size_code <= code;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        ring.set_ring_code(code);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                i_ready <= no_gaps || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            observed = t_result'({o_result_kind, o_packet_byte, o_last_flag,
                                  o_frame_length, o_frame_status, o_read_pointer});
            ring.check_result(observed);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no request moved for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned phase_start;
        logic [1:0]  random_codes [5];
        random_codes = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd1};
        ring = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_ring_size(2'd3);

        send_frame(16'h0001, LEN_NOT_READY);
        send_frame(16'hFFFF, 16'd0);
        send_frame(16'h0001, 16'd1);
        send_frame(16'h8001, 16'd2);
        send_frame(16'h0003, 16'd3);
        send_frame(16'h0005, 16'd4);
        send_frame(16'h0001, 16'd5);
        send_frame(16'hFFFF, 16'd7);
        send_frame(16'h0001, LEN_NOT_READY);
        send_frame(16'hFFFE, 16'h1234);
        send_frame(16'h0000, LEN_NOT_READY);
        send_frame(16'h00FF, 16'd64);

        for (int p = 0; p < 5; p++) begin
            wait_drained();
            write_ring_size(random_codes[p]);
            if (p == 1) begin
                rx_hold_req = 1'b1;
            end
            no_gaps     = (p == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 2) begin
                    wait_drained();
                end
                send_random_frame();
            end
        end
        wait_drained();

        $display("Sent %0d ring bytes over ring size codes 0 to 3, with random gaps and a long output stall.",
                 items_sent);
        $display("Results: %0d packet bytes, %0d empty frames, %0d not ready, %0d bad status.",
                 ring.kind_seen[KIND_PACKET], ring.kind_seen[KIND_EMPTY],
                 ring.kind_seen[KIND_NOT_READY], ring.kind_seen[KIND_BAD_STATUS]);
        if (ring.errors == 0 && ring.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
